// ===== sv/booth_radix2_multiplier_defines.svh =====
// assertion macros shared by the rtl files
`ifndef BOOTH_RADIX2_MULTIPLIER_DEFINES_SVH
`define BOOTH_RADIX2_MULTIPLIER_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define BRM_ASSERT_IMPLY(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define BRM_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ===== sv/brm_pkg.sv =====
`default_nettype none

package brm_pkg;

   localparam int OPERAND_WIDTH_DEFAULT = 16;
   localparam int IN_WIDTH              = 16;
   localparam int PRODUCT_WIDTH         = 32;
   localparam int STEPS_PER_STAGE       = 2;

   typedef enum logic [1:0] {
      BOOTH_KEEP0 = 2'b00,
      BOOTH_ADD   = 2'b01,
      BOOTH_SUB   = 2'b10,
      BOOTH_KEEP1 = 2'b11
   } booth_op_type;

endpackage

`default_nettype wire

// ===== sv/brm_stage.sv =====
`default_nettype none

`include "booth_radix2_multiplier_defines.svh"

module brm_stage #(
   parameter int OPERAND_WIDTH = brm_pkg::OPERAND_WIDTH_DEFAULT,
   parameter int FIRST_STEP    = 0
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     up_valid,
   input  wire logic [OPERAND_WIDTH-1:0] up_md,
   input  wire logic [OPERAND_WIDTH-1:0] up_ac,
   input  wire logic [OPERAND_WIDTH-1:0] up_q,
   input  wire logic                     up_prev,
   output logic                          valid_ff,
   output logic [OPERAND_WIDTH-1:0]      md_ff,
   output logic [OPERAND_WIDTH-1:0]      ac_ff,
   output logic [OPERAND_WIDTH-1:0]      q_ff,
   output logic                          prev_ff
);
   import brm_pkg::*;

   localparam int W = OPERAND_WIDTH;

   logic         valid_in;
   logic [W-1:0] ac_in;
   logic [W-1:0] q_in;
   logic         prev_in;

   logic [W-1:0] ac_t   [STEPS_PER_STAGE+1];
   logic [W-1:0] q_t    [STEPS_PER_STAGE+1];
   logic         prev_t [STEPS_PER_STAGE+1];
   logic [W-1:0] sum_t  [STEPS_PER_STAGE];

   always_comb begin
      ac_t[0]   = up_ac;
      q_t[0]    = up_q;
      prev_t[0] = up_prev;
      for (int i = 0; i < STEPS_PER_STAGE; i++) begin
         case (booth_op_type'({q_t[i][0], prev_t[i]}))
            BOOTH_ADD: sum_t[i] = ac_t[i] + up_md;
            BOOTH_SUB: sum_t[i] = ac_t[i] - up_md;
            default:   sum_t[i] = ac_t[i];
         endcase
         if (FIRST_STEP + i < W) begin
            prev_t[i+1] = q_t[i][0];
            q_t[i+1]    = {sum_t[i][0], q_t[i][W-1:1]};
            ac_t[i+1]   = {sum_t[i][W-1], sum_t[i][W-1:1]};
         end else begin
            prev_t[i+1] = prev_t[i];
            q_t[i+1]    = q_t[i];
            ac_t[i+1]   = ac_t[i];
         end
      end
      valid_in = up_valid;
      ac_in    = ac_t[STEPS_PER_STAGE];
      q_in     = q_t[STEPS_PER_STAGE];
      prev_in  = prev_t[STEPS_PER_STAGE];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      md_ff   <= up_md;
      ac_ff   <= ac_in;
      q_ff    <= q_in;
      prev_ff <= prev_in;
   end

   `BRM_ASSERT_NEXT(a_valid_moves, up_valid, valid_ff, "stage lost an item")
   `BRM_ASSERT_NEXT(a_no_phantom, !up_valid, !valid_ff, "stage invented an item")

endmodule

`default_nettype wire

// ===== sv/booth_radix2_multiplier.sv =====
`default_nettype none

// booth_radix2_multiplier
// signed radix-2 booth multiplier, fully pipelined
// input: drive req_multiplicand and req_multiplier with start high; the item
//   is taken at any rising edge where start is high and busy is low. busy is
//   always low, so one item may enter on every cycle
// output: rsp_valid pulses for one cycle with rsp_product; results leave in
//   the order the items entered and must be taken in that cycle
// pipeline: each registered stage performs two booth add/sub and shift
//   steps, and the last stage only one when OPERAND_WIDTH is odd
// throughput: one item per cycle
// operands are sign-extended or cut to OPERAND_WIDTH; the accumulator wraps
//   at OPERAND_WIDTH bits, and AC:Q is cut or zero-extended to 32 bits
// reset: synchronous, clears the stage valid bits; items in flight are
//   dropped and no result appears until new items have passed through
// there is no output stall; the receiver always takes rsp_product

`include "booth_radix2_multiplier_defines.svh"

module booth_radix2_multiplier #(
   parameter int OPERAND_WIDTH = brm_pkg::OPERAND_WIDTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic signed [brm_pkg::IN_WIDTH-1:0]  req_multiplicand,
   input  wire logic signed [brm_pkg::IN_WIDTH-1:0]  req_multiplier,
   output logic                                      rsp_valid,
   output logic signed [brm_pkg::PRODUCT_WIDTH-1:0]  rsp_product
);
   import brm_pkg::*;

   localparam int W          = OPERAND_WIDTH;
   localparam int NUM_STAGES = (W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

   logic         valid_s [NUM_STAGES+1];
   logic [W-1:0] md_s    [NUM_STAGES+1];
   logic [W-1:0] ac_s    [NUM_STAGES+1];
   logic [W-1:0] q_s     [NUM_STAGES+1];
   logic         prev_s  [NUM_STAGES+1];
   logic         zero_md;

   assign busy = 1'b0;

   assign valid_s[0] = start && !busy;
   assign md_s[0]    = W'(req_multiplicand);
   assign q_s[0]     = W'(req_multiplier);
   assign ac_s[0]    = '0;
   assign prev_s[0]  = 1'b0;

   for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
      brm_stage #(
         .OPERAND_WIDTH(W),
         .FIRST_STEP   (s * STEPS_PER_STAGE)
      ) u_stage (
         .clock   (clock),
         .reset   (reset),
         .up_valid(valid_s[s]),
         .up_md   (md_s[s]),
         .up_ac   (ac_s[s]),
         .up_q    (q_s[s]),
         .up_prev (prev_s[s]),
         .valid_ff(valid_s[s+1]),
         .md_ff   (md_s[s+1]),
         .ac_ff   (ac_s[s+1]),
         .q_ff    (q_s[s+1]),
         .prev_ff (prev_s[s+1])
      );
   end

   assign rsp_valid   = valid_s[NUM_STAGES];
   assign rsp_product = PRODUCT_WIDTH'({ac_s[NUM_STAGES], q_s[NUM_STAGES]});

   assign zero_md = rsp_valid && (md_s[NUM_STAGES] == '0) && !prev_s[NUM_STAGES];

   `BRM_ASSERT_IMPLY(a_zero_md, zero_md, rsp_product == '0, "zero multiplicand, nonzero product")
   `BRM_ASSERT_IMPLY(a_never_busy, 1'b1, !busy, "busy raised")
   `BRM_ASSERT_IMPLY(a_product_known, rsp_valid, !$isunknown(rsp_product), "unknown product")

endmodule

`default_nettype wire
